// ===== rtl/core/gtb_pkg.sv =====
// ----------------------------------------------------------------------------
// gtb_pkg: shared types and constants of the 5x7 glyph text blitter
// Font table, character codes, and the job handed from the front end to the
// halfword writer.
// ----------------------------------------------------------------------------
`default_nettype none

package gtb_pkg;

    // One glyph: seven rows of five pixels, row 0 on top, bit 4 leftmost.
    typedef logic [0:6][4:0] t_glyph;

    // Number of glyphs in the font and the width of a glyph index.
    localparam int GLYPH_COUNT = 39;
    localparam int GLYPH_IDX_W = 6;

    // Glyph numbering: letters first, then digits, then the punctuation.
    localparam logic [GLYPH_IDX_W-1:0] IDX_DIGIT0 = 6'd26;
    localparam logic [GLYPH_IDX_W-1:0] IDX_COLON  = 6'd36;
    localparam logic [GLYPH_IDX_W-1:0] IDX_SLASH  = 6'd37;
    localparam logic [GLYPH_IDX_W-1:0] IDX_DASH   = 6'd38;

    // ASCII codes recognized by the font.
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    // Request kinds on the input channel.
    localparam logic ACT_PLACE = 1'b0;
    localparam logic ACT_DRAW  = 1'b1;

    // Halfword offset of framebuffer page 1.
    localparam logic [15:0] PAGE_OFFSET = 16'd20480;

    // Cursor movement after each character.
    localparam logic signed [9:0] CURSOR_STEP = 10'sd6;
    localparam logic signed [9:0] CURSOR_MAX  = 10'sd511;

    // Glyph extent used for the on-screen check.
    localparam logic [11:0] GLYPH_W_M1 = 12'd5;
    localparam logic [11:0] GLYPH_H_M1 = 12'd7;

    // Result of decoding a character code.
    typedef struct packed {
        logic                   known;
        logic [GLYPH_IDX_W-1:0] idx;
    } t_glyph_sel;

    // A glyph that will be drawn: address of its top-left halfword,
    // replicated ink, and whether it starts on an odd pixel.
    typedef struct packed {
        logic [15:0] base;
        logic [15:0] data;
        logic        odd;
    } t_job;

    // Font table.
    localparam t_glyph FONT [0:GLYPH_COUNT-1] = '{
        {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
        {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
        {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
        {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
        {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
        {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14},
        {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31},
        {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12},
        {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
        {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
        {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
        {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
        {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
        {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
        {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
        {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
        {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
        {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
        {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
        {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
        {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
        {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31},
        {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
        {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
        {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
        {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
        {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
        {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
        {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
        {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
        {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
        {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14},
        {5'd0,  5'd4,  5'd4,  5'd0,  5'd4,  5'd4,  5'd0},
        {5'd0,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd0},
        {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0}
    };

    // Map an ASCII code onto a glyph index.
    function automatic t_glyph_sel glyph_lookup(input logic [7:0] ch);
        t_glyph_sel sel;
        sel.known = 1'b0;
        sel.idx   = '0;
        if (ch >= CH_A && ch <= CH_Z) begin
            sel.known = 1'b1;
            sel.idx   = GLYPH_IDX_W'(ch - CH_A);
        end else if (ch >= CH_0 && ch <= CH_9) begin
            sel.known = 1'b1;
            sel.idx   = GLYPH_IDX_W'(ch - CH_0) + IDX_DIGIT0;
        end else if (ch == CH_COLON) begin
            sel.known = 1'b1;
            sel.idx   = IDX_COLON;
        end else if (ch == CH_SLASH) begin
            sel.known = 1'b1;
            sel.idx   = IDX_SLASH;
        end else if (ch == CH_DASH) begin
            sel.known = 1'b1;
            sel.idx   = IDX_DASH;
        end
        return sel;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/glyph_text_blitter_5x7_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_text_blitter_5x7_unit: 5x7 font text blitter, top level
// Decodes place and draw requests and turns each drawn character into masked
// halfword writes for an 8-bit-per-pixel framebuffer.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid / o_ready) carries requests. A place request
// (i_action low) loads the cursor and the ink from i_start_x, i_start_y and
// i_ink_colour and yields no writes. A draw request looks up i_char_code in
// the font and, if the glyph fits on screen, yields one write request per
// halfword touched, row by row, with o_last_write on the final one. The
// cursor then moves right by six pixels, saturating at 511.
// The output channel (o_valid / i_ready) carries the writes, one per cycle
// at most. The first write of a glyph passes through the job holding register,
// the glyph-in-flight register and the output register once the draw request
// is accepted. A glyph issues at most 21 writes; the generator holds one glyph
// in flight and one waiting, and loads the waiting one as the last write goes.
// i_cfg_we with i_cfg_wdata selects the framebuffer page; write it while no
// writes are pending. Synchronous reset clears the cursor, ink, page and all
// pending work. When the receiver stalls, the output register holds and the
// input stops accepting once the waiting job slot is full.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_text_blitter_5x7_unit #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 160
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration.
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    // Request channel.
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_action,
    input  wire  [9:0]  i_start_x,
    input  wire  [9:0]  i_start_y,
    input  wire  [7:0]  i_ink_colour,
    input  wire  [7:0]  i_char_code,
    // Write channel.
    output logic        o_valid,
    input  wire         i_ready,
    output logic [15:0] o_vram_halfword,
    output logic [15:0] o_write_data,
    output logic [1:0]  o_byte_enable,
    output logic        o_last_write
);

    localparam int          ROW_PITCH = SCREEN_WIDTH / 2;
    localparam logic [11:0] SCR_W     = 12'(SCREEN_WIDTH);
    localparam logic [11:0] SCR_H     = 12'(SCREEN_HEIGHT);

    // Drawing state.
    logic                   r_frame_page;
    logic signed [9:0]      r_cursor_x;
    logic signed [9:0]      r_cursor_y;
    logic [7:0]             r_ink;
    gtb_pkg::t_glyph        r_font;

    logic                   accept;
    logic                   draw;
    logic                   on_screen;
    gtb_pkg::t_glyph_sel    sel;
    logic [gtb_pkg::GLYPH_IDX_W-1:0] rom_idx;
    logic signed [9:0]      n_cursor_x;
    logic [15:0]            row_base;
    logic [15:0]            page_base;
    gtb_pkg::t_job          job;

    assign accept = i_valid && o_ready;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_page <= 1'b0;
        end else if (i_cfg_we) begin
            r_frame_page <= i_cfg_wdata;
        end
    end

    // Character decode and on-screen check against the current cursor.
    assign sel     = gtb_pkg::glyph_lookup(i_char_code);
    assign rom_idx = sel.known ? sel.idx : '0;
    assign on_screen = !r_cursor_x[9] && !r_cursor_y[9]
                    && ({2'b00, r_cursor_x} + gtb_pkg::GLYPH_W_M1) < SCR_W
                    && ({2'b00, r_cursor_y} + gtb_pkg::GLYPH_H_M1) < SCR_H;
    assign draw = accept && (i_action == gtb_pkg::ACT_DRAW) && sel.known && on_screen;

    // Top-left halfword address of the glyph.
    assign row_base  = 16'(r_cursor_y[8:0]) * 16'(ROW_PITCH);
    assign page_base = r_frame_page ? gtb_pkg::PAGE_OFFSET : 16'd0;
    assign job.base  = page_base + row_base + 16'(r_cursor_x[9:1]);
    assign job.data  = {r_ink, r_ink};
    assign job.odd   = r_cursor_x[0];

    // Cursor advance, saturating at the top of the range.
    assign n_cursor_x = (r_cursor_x >= gtb_pkg::CURSOR_MAX - gtb_pkg::CURSOR_STEP)
                      ? gtb_pkg::CURSOR_MAX : r_cursor_x + gtb_pkg::CURSOR_STEP;

    // Cursor and ink update on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_ink      <= '0;
        end else if (accept) begin
            case (i_action)
                gtb_pkg::ACT_PLACE: begin
                    r_cursor_x <= i_start_x;
                    r_cursor_y <= i_start_y;
                    r_ink      <= i_ink_colour;
                end
                gtb_pkg::ACT_DRAW: begin
                    r_cursor_x <= n_cursor_x;
                end
                default: begin
                    r_cursor_x <= r_cursor_x;
                end
            endcase
        end
    end

    // Font ROM with registered read, captured alongside the job.
    always_ff @(posedge i_clk) begin
        if (draw) begin
            r_font <= gtb_pkg::FONT[rom_idx];
        end
    end

    gtb_writer #(
        .ROW_PITCH (ROW_PITCH)
    ) u_writer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (draw),
        .i_job           (job),
        .i_font          (r_font),
        .o_job_ready     (o_ready),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_vram_halfword (o_vram_halfword),
        .o_write_data    (o_write_data),
        .o_byte_enable   (o_byte_enable),
        .o_last_write    (o_last_write)
    );

endmodule

`default_nettype wire

// ===== rtl/core/gtb_writer.sv =====
// ----------------------------------------------------------------------------
// gtb_writer: halfword write generator
// Holds one waiting glyph job and one glyph in flight, and issues one masked
// halfword write per cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gtb_writer #(
    parameter int ROW_PITCH = 120
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // Job from the front end; the font rows arrive from its ROM register.
    input  wire                 i_job_valid,
    input  gtb_pkg::t_job       i_job,
    input  gtb_pkg::t_glyph     i_font,
    output logic                o_job_ready,
    // Write requests toward the framebuffer.
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [15:0]         o_vram_halfword,
    output logic [15:0]         o_write_data,
    output logic [1:0]          o_byte_enable,
    output logic                o_last_write
);

    // Waiting job.
    logic          r_s1_valid;
    gtb_pkg::t_job r_s1_job;

    // Glyph in flight: byte enables per row and per halfword.
    logic [6:0][2:0][1:0] r_en;
    logic [6:0][2:0][1:0] n_en;
    logic [6:0][2:0][1:0] load_en;
    gtb_pkg::t_job        r_cur;

    // Output stage.
    logic        r_out_valid;
    logic [15:0] r_out_addr;
    logic [15:0] r_out_data;
    logic [1:0]  r_out_be;
    logic        r_out_last;

    logic        out_free;
    logic        emit;
    logic        load;
    logic        found;
    logic [2:0]  sel_row;
    logic [1:0]  sel_k;
    logic        last;
    logic [15:0] slot_addr;

    // Byte enables of a fresh glyph, from the font rows and the pixel phase.
    always_comb begin
        for (int r = 0; r < 7; r++) begin
            if (r_s1_job.odd) begin
                load_en[r][0] = {i_font[r][4], 1'b0};
                load_en[r][1] = {i_font[r][2], i_font[r][3]};
                load_en[r][2] = {i_font[r][0], i_font[r][1]};
            end else begin
                load_en[r][0] = {i_font[r][3], i_font[r][4]};
                load_en[r][1] = {i_font[r][1], i_font[r][2]};
                load_en[r][2] = {1'b0, i_font[r][0]};
            end
        end
    end

    // Pick the first halfword that still has enabled bytes.
    always_comb begin
        found   = 1'b0;
        sel_row = '0;
        sel_k   = '0;
        for (int r = 0; r < 7; r++) begin
            for (int k = 0; k < 3; k++) begin
                if (!found && r_en[r][k] != 2'b00) begin
                    found   = 1'b1;
                    sel_row = 3'(r);
                    sel_k   = 2'(k);
                end
            end
        end
    end

    // Retire the chosen halfword; it is the last one when nothing remains.
    always_comb begin
        n_en = r_en;
        n_en[sel_row][sel_k] = 2'b00;
    end

    assign last      = (n_en == '0);
    assign out_free  = !r_out_valid || i_ready;
    assign emit      = found && out_free;
    assign load      = r_s1_valid && (!found || (emit && last));
    assign slot_addr = r_cur.base + 16'(16'(sel_row) * 16'(ROW_PITCH)) + 16'(sel_k);

    assign o_job_ready = !r_s1_valid || load;

    // Job holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_job_ready) begin
            r_s1_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_ready && i_job_valid) begin
            r_s1_job <= i_job;
        end
    end

    // Glyph in flight: load a new one or clear the halfword just issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '0;
        end else if (load) begin
            r_en <= load_en;
        end else if (emit) begin
            r_en <= n_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= r_s1_job;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_addr <= slot_addr;
            r_out_data <= r_cur.data;
            r_out_be   <= r_en[sel_row][sel_k];
            r_out_last <= last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_vram_halfword = r_out_addr;
    assign o_write_data    = r_out_data;
    assign o_byte_enable   = r_out_be;
    assign o_last_write    = r_out_last;

`ifndef ASSERT_OFF
    // Every glyph in the font touches at least one halfword.
    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_en != '0))
        else $error("glyph loaded with no enabled bytes");

    // An issued write always enables at least one byte.
    a_be_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_enable != 2'b00))
        else $error("write request with empty byte enable");

    // A waiting job is kept until it moves into the writer.
    a_job_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !load) |=> r_s1_valid)
        else $error("waiting glyph job lost");

    // A new glyph starts only after the previous one issued its last write.
    a_load_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && found) |-> (emit && last))
        else $error("glyph replaced before its last write");
`endif

endmodule

`default_nettype wire

// ===== tb/glyph_text_blitter_5x7_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_text_blitter_5x7_unit_test: self-checking bench for the text blitter
// Feeds place and draw requests through the request channel, predicts every
// masked halfword write from a local font renderer, and checks the write
// channel field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------

module glyph_text_blitter_5x7_unit_test;

    localparam int SCREEN_W    = 240;
    localparam int SCREEN_H    = 160;
    localparam int ROW_PITCH   = SCREEN_W / 2;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 8;

    // One request as the sender presents it.
    typedef struct packed {
        logic       action;
        logic [9:0] start_x;
        logic [9:0] start_y;
        logic [7:0] ink;
        logic [7:0] char_code;
    } t_text_req;

    // One halfword write as the block should emit it.
    typedef struct packed {
        logic [15:0] halfword;
        logic [15:0] data;
        logic [1:0]  byte_en;
        logic        last;
    } t_vram_write;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = gtb_pkg::ACT_PLACE;
    logic [9:0]  i_start_x = '0;
    logic [9:0]  i_start_y = '0;
    logic [7:0]  i_ink_colour = '0;
    logic [7:0]  i_char_code = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_vram_halfword;
    logic [15:0] o_write_data;
    logic [1:0]  o_byte_enable;
    logic        o_last_write;

    glyph_text_blitter_5x7_unit #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_ink_colour   (i_ink_colour),
        .i_char_code    (i_char_code),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_vram_halfword(o_vram_halfword),
        .o_write_data   (o_write_data),
        .o_byte_enable  (o_byte_enable),
        .o_last_write   (o_last_write)
    );

    always #5 i_clk = ~i_clk;

    t_text_req   pending_req_q[$];
    t_vram_write vram_write_q[$];
    t_text_req   drv_req;
    int unsigned issued_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned checked_cnt = 0;
    int unsigned error_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // Local copy of the blitter state.
    logic signed [9:0] font_cursor_x = '0;
    logic signed [9:0] font_cursor_y = '0;
    logic [7:0]        font_ink = '0;
    logic              font_page = 1'b0;

    // Glyph index of a character code, -1 when the font has no such glyph.
    function automatic int glyph_of(input logic [7:0] ch);
        if (ch >= gtb_pkg::CH_A && ch <= gtb_pkg::CH_Z) return int'(ch - gtb_pkg::CH_A);
        if (ch >= gtb_pkg::CH_0 && ch <= gtb_pkg::CH_9)
            return int'(ch - gtb_pkg::CH_0) + int'(gtb_pkg::IDX_DIGIT0);
        if (ch == gtb_pkg::CH_COLON) return int'(gtb_pkg::IDX_COLON);
        if (ch == gtb_pkg::CH_SLASH) return int'(gtb_pkg::IDX_SLASH);
        if (ch == gtb_pkg::CH_DASH) return int'(gtb_pkg::IDX_DASH);
        return -1;
    endfunction

    // Apply one accepted request to the local state and queue its writes.
    task automatic render_request(input t_text_req req);
        int          gidx;
        int          x;
        int          y;
        int          n;
        logic [15:0] base;
        logic [4:0]  bits;
        logic [1:0]  en[3];
        logic [15:0] addr_a[21];
        logic [1:0]  en_a[21];
        t_vram_write wr;
        if (req.action == gtb_pkg::ACT_PLACE) begin
            font_cursor_x = req.start_x;
            font_cursor_y = req.start_y;
            font_ink = req.ink;
            return;
        end
        gidx = glyph_of(req.char_code);
        x = font_cursor_x;
        y = font_cursor_y;
        n = 0;
        if (gidx >= 0 && x >= 0 && x + 5 < SCREEN_W && y >= 0 && y + 7 < SCREEN_H) begin
            base = (font_page ? gtb_pkg::PAGE_OFFSET : 16'd0)
                 + 16'(y * ROW_PITCH) + 16'(x / 2);
            for (int row = 0; row < 7; row++) begin
                bits = gtb_pkg::FONT[gidx][row];
                // Bit 4 is the leftmost pixel; an odd start puts it in a high byte.
                if (x % 2 == 1) begin
                    en[0] = {bits[4], 1'b0};
                    en[1] = {bits[2], bits[3]};
                    en[2] = {bits[0], bits[1]};
                end else begin
                    en[0] = {bits[3], bits[4]};
                    en[1] = {bits[1], bits[2]};
                    en[2] = {1'b0, bits[0]};
                end
                for (int k = 0; k < 3; k++) begin
                    if (en[k] != 2'b00) begin
                        addr_a[n] = base + 16'(row * ROW_PITCH) + 16'(k);
                        en_a[n] = en[k];
                        n++;
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            wr.halfword = addr_a[i];
            wr.data = {font_ink, font_ink};
            wr.byte_en = en_a[i];
            wr.last = (i == n - 1);
            vram_write_q.push_back(wr);
        end
        font_cursor_x = (x >= 505) ? 10'sd511 : 10'(x + 6);
    endtask

    // Request driver: presents queued requests, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                render_request(drv_req);
                accepted_cnt++;
            end
            if (!i_valid || o_ready) begin
                if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_req = pending_req_q.pop_front();
                    i_valid <= 1'b1;
                    i_action <= drv_req.action;
                    i_start_x <= drv_req.start_x;
                    i_start_y <= drv_req.start_y;
                    i_ink_colour <= drv_req.ink;
                    i_char_code <= drv_req.char_code;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Write monitor: stalls at random and checks each accepted write.
    always @(posedge i_clk) begin
        t_vram_write exp_wr;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (vram_write_q.size() == 0) begin
                    $error("unexpected write: halfword %0d data %h enable %b last %b",
                           o_vram_halfword, o_write_data, o_byte_enable, o_last_write);
                    error_cnt++;
                end else begin
                    exp_wr = vram_write_q.pop_front();
                    checked_cnt++;
                    if (o_vram_halfword !== exp_wr.halfword) begin
                        $error("vram_halfword: expected %0d, got %0d",
                               exp_wr.halfword, o_vram_halfword);
                        error_cnt++;
                    end
                    if (o_write_data !== exp_wr.data) begin
                        $error("write_data: expected %h, got %h", exp_wr.data, o_write_data);
                        error_cnt++;
                    end
                    if (o_byte_enable !== exp_wr.byte_en) begin
                        $error("byte_enable: expected %b, got %b",
                               exp_wr.byte_en, o_byte_enable);
                        error_cnt++;
                    end
                    if (o_last_write !== exp_wr.last) begin
                        $error("last_write: expected %b, got %b", exp_wr.last, o_last_write);
                        error_cnt++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("glyph_text_blitter_5x7_unit: mismatch");
            $finish;
        end
    end

    task automatic push_place(input int x, input int y, input int ink);
        t_text_req req;
        req.action = gtb_pkg::ACT_PLACE;
        req.start_x = 10'(x);
        req.start_y = 10'(y);
        req.ink = 8'(ink);
        req.char_code = 8'($urandom);
        pending_req_q.push_back(req);
        issued_cnt++;
    endtask

    task automatic push_draw(input logic [7:0] ch);
        t_text_req req;
        req.action = gtb_pkg::ACT_DRAW;
        req.start_x = 10'($urandom);
        req.start_y = 10'($urandom);
        req.ink = 8'($urandom);
        req.char_code = ch;
        pending_req_q.push_back(req);
        issued_cnt++;
    endtask

    // A character the font knows, picked uniformly.
    function automatic logic [7:0] random_known_char();
        int r;
        r = $urandom_range(38);
        if (r < 26) return gtb_pkg::CH_A + 8'(r);
        if (r < 36) return gtb_pkg::CH_0 + 8'(r - 26);
        if (r == 36) return gtb_pkg::CH_COLON;
        if (r == 37) return gtb_pkg::CH_SLASH;
        return gtb_pkg::CH_DASH;
    endfunction

    // Mostly a cursor placement on screen followed by a short word, with some
    // placements anywhere and stray character codes mixed in.
    task automatic queue_text(input int count);
        int r;
        int done;
        done = 0;
        while (done < count) begin
            r = $urandom_range(99);
            if (r < 75) begin
                push_place($urandom_range(234), $urandom_range(152), $urandom_range(255));
                done++;
                for (int k = $urandom_range(1, 5); k > 0; k--) begin
                    push_draw(random_known_char());
                    done++;
                end
            end else if (r < 87) begin
                push_place($urandom_range(1023), $urandom_range(1023), $urandom_range(255));
                done++;
            end else begin
                push_draw(8'($urandom));
                done++;
            end
        end
    endtask

    // Wait until every request is accepted and every write has come out.
    task automatic wait_idle();
        while (accepted_cnt != issued_cnt || vram_write_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_page(input logic page);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= page;
        font_page = page;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int send_pct, input int stall_pct, input int count);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        queue_text(count);
        wait_idle();
    endtask

    // Test sequence.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset cursor, screen corners, odd and even starts,
        // punctuation with empty rows, unknown codes, off-screen glyphs
        // and cursor saturation.
        push_draw(gtb_pkg::CH_A);
        push_place(233, 152, 255);
        push_draw(gtb_pkg::CH_Z);
        push_place(0, 0, 'h5A);
        push_draw(gtb_pkg::CH_0);
        push_draw(gtb_pkg::CH_9);
        push_draw(gtb_pkg::CH_COLON);
        push_draw(gtb_pkg::CH_SLASH);
        push_draw(gtb_pkg::CH_DASH);
        push_place(1, 7, 'hA5);
        push_draw("M");
        push_draw(8'h00);
        push_draw(8'hFF);
        push_place(234, 10, 1);
        push_draw("I");
        push_draw("H");
        push_place(-1, 5, 'h33);
        push_draw(gtb_pkg::CH_A);
        push_place(10, 153, 'h44);
        push_draw("E");
        push_place(508, -512, 'h80);
        push_draw(gtb_pkg::CH_A);
        push_draw(gtb_pkg::CH_A);
        push_place(511, 511, 255);
        push_draw("W");
        wait_idle();

        write_page(1'b1);
        run_phase(67, 0, 38);
        write_page(1'b0);
        run_phase(0, 67, 38);
        write_page(1'b1);
        run_phase(16, 16, 38);
        run_phase(0, 0, 38);

        $display("Covered %0d requests and %0d checked halfword writes on both pages,",
                 accepted_cnt, checked_cnt);
        $display("with sender gaps and receiver stalls in separate and shared phases.");
        if (error_cnt == 0 && vram_write_q.size() == 0) begin
            $display("glyph_text_blitter_5x7_unit: match");
        end else begin
            $display("glyph_text_blitter_5x7_unit: mismatch");
        end
        $finish;
    end

endmodule
